/* design/mclp_pkg.sv */
// Package: shared constants and types for the motor command line parser.
`timescale 1ns / 1ps

package mclp_pkg;

    localparam int unsigned LINE_LEN = 100;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned MAG_W    = 31;
    localparam int unsigned ID_W     = 4;
    localparam int unsigned SPEED_W  = 32;

    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [MAG_W-1:0]   t_mag;
    typedef logic [ID_W-1:0]    t_id;
    typedef logic [7:0]         t_byte;

    localparam t_byte CH_NEWLINE = 8'd10;
    localparam t_byte CH_M       = 8'h6D;
    localparam t_byte CH_COLON   = 8'h3A;
    localparam t_byte CH_MINUS   = 8'h2D;
    localparam t_byte CH_ZERO    = 8'h30;
    localparam t_byte CH_NINE    = 8'h39;

    localparam t_mag MAG_MAX = {MAG_W{1'b1}};

    localparam t_pos POS_CMD   = POS_W'(0);
    localparam t_pos POS_ID    = POS_W'(1);
    localparam t_pos POS_COLON = POS_W'(2);
    localparam t_pos POS_SIGN  = POS_W'(3);
    localparam t_pos POS_LIMIT = POS_W'(LINE_LEN);

    typedef struct packed {
        t_id                       motor_id;
        logic signed [SPEED_W-1:0] motor_speed;
    } t_result;

endpackage

/* design/mclp_if.sv */
// Interfaces: byte input channel and command result channel.
`timescale 1ns / 1ps

interface mclp_byte_if;
    logic             valid;
    logic             ready;
    mclp_pkg::t_byte  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mclp_result_if;
    logic                                 valid;
    logic                                 ready;
    mclp_pkg::t_id                        motor_id;
    logic signed [mclp_pkg::SPEED_W-1:0]  motor_speed;

    modport source (output valid, output motor_id, output motor_speed, input ready);
    modport sink   (input valid, input motor_id, input motor_speed, output ready);
endinterface

/* design/motor_command_line_parser.sv */
// Top level: motor command line parser, byte input to command results.
// The ending newline is captured in the input register, and its result is then captured in the result register.
// Throughput: one byte per cycle while the result channel is not stalled.
// The input register and the result register are each one stage, so a
// stalled result holds back one byte.
// Reset (synchronous, active low) clears line state and both valid flags.
`timescale 1ns / 1ps

module motor_command_line_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mclp_byte_if.sink      i_rx,
    mclp_result_if.source  o_cmd
);

    logic              r_in_valid, n_in_valid;
    mclp_pkg::t_byte   r_in_byte;
    logic              out_free;
    logic              advance;
    logic              res_valid;
    mclp_pkg::t_result result;

    // stage one moves whenever the result register can take a result
    assign advance    = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_rx.ready) begin
            n_in_valid = i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mclp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    mclp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (result),
        .o_free   (out_free),
        .o_cmd    (o_cmd)
    );

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_byte))
        else $error("input stage lost a byte while blocked");

    a_result_from_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> advance && (r_in_byte == mclp_pkg::CH_NEWLINE))
        else $error("result raised without a newline");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.motor_id <= mclp_pkg::ID_W'(9)))
        else $error("motor id out of range");

endmodule

/* design/mclp_parse_core.sv */
// Parse core: per-byte line state update and command result formation.
`timescale 1ns / 1ps

module mclp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  mclp_pkg::t_byte   i_byte,
    output logic              o_res_valid,
    output mclp_pkg::t_result o_result
);

    localparam int unsigned MAG_W_X = mclp_pkg::MAG_W + 4;

    mclp_pkg::t_pos r_pos,    n_pos;
    logic           r_start,  n_start;
    mclp_pkg::t_id  r_digit,  n_digit;
    logic           r_colon,  n_colon;
    logic           r_neg,    n_neg;
    logic           r_active, n_active;
    mclp_pkg::t_mag r_mag,    n_mag;

    logic               is_digit;
    mclp_pkg::t_id      digit_val;
    logic [MAG_W_X-1:0] acc;
    mclp_pkg::t_mag     mag_add;

    assign is_digit  = (i_byte >= mclp_pkg::CH_ZERO) && (i_byte <= mclp_pkg::CH_NINE);
    assign digit_val = mclp_pkg::ID_W'(i_byte - mclp_pkg::CH_ZERO);

    // mag * 10 + digit, saturated
    assign acc = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
               + {{(MAG_W_X - mclp_pkg::ID_W){1'b0}}, digit_val};
    assign mag_add = (acc > {4'b0, mclp_pkg::MAG_MAX}) ? mclp_pkg::MAG_MAX
                                                       : acc[mclp_pkg::MAG_W-1:0];

    assign o_result.motor_id    = r_digit;
    assign o_result.motor_speed = r_neg ? (mclp_pkg::SPEED_W'(0) - {1'b0, r_mag})
                                        : {1'b0, r_mag};

    always_comb begin
        n_pos       = r_pos;
        n_start     = r_start;
        n_digit     = r_digit;
        n_colon     = r_colon;
        n_neg       = r_neg;
        n_active    = r_active;
        n_mag       = r_mag;
        o_res_valid = 1'b0;
        if (i_step) begin
            if (i_byte == mclp_pkg::CH_NEWLINE) begin
                o_res_valid = r_start && r_colon;
                n_pos       = '0;
                n_start     = 1'b0;
                n_digit     = '0;
                n_colon     = 1'b0;
                n_neg       = 1'b0;
                n_active    = 1'b0;
                n_mag       = '0;
            end else if (r_pos < mclp_pkg::POS_LIMIT) begin
                n_pos = r_pos + mclp_pkg::POS_W'(1);
                case (r_pos)
                    mclp_pkg::POS_CMD: begin
                        n_start = (i_byte == mclp_pkg::CH_M);
                    end
                    mclp_pkg::POS_ID: begin
                        n_digit = is_digit ? digit_val : '0;
                    end
                    mclp_pkg::POS_COLON: begin
                        n_colon = (i_byte == mclp_pkg::CH_COLON);
                    end
                    mclp_pkg::POS_SIGN: begin
                        if (i_byte == mclp_pkg::CH_MINUS) begin
                            n_neg    = 1'b1;
                            n_active = 1'b1;
                        end else if (is_digit) begin
                            n_active = 1'b1;
                            n_mag    = mag_add;
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                    default: begin
                        if (r_active && is_digit) begin
                            n_mag = mag_add;
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_start  <= 1'b0;
            r_digit  <= '0;
            r_colon  <= 1'b0;
            r_neg    <= 1'b0;
            r_active <= 1'b0;
            r_mag    <= '0;
        end else begin
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_digit  <= n_digit;
            r_colon  <= n_colon;
            r_neg    <= n_neg;
            r_active <= n_active;
            r_mag    <= n_mag;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mclp_pkg::POS_LIMIT)
        else $error("line position past limit");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_byte == mclp_pkg::CH_NEWLINE) |=> (r_pos == '0) && (r_mag == '0))
        else $error("newline did not clear line state");

    a_active_after_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pos > mclp_pkg::POS_SIGN))
        else $error("speed digits active before sign position");

endmodule

/* design/mclp_out_stage.sv */
// Output stage: result register holding one command until its transfer.
`timescale 1ns / 1ps

module mclp_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  mclp_pkg::t_result     i_result,
    output logic                  o_free,
    mclp_result_if.source         o_cmd
);

    logic              r_valid, n_valid;
    mclp_pkg::t_result r_result;

    assign o_free = !r_valid || o_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_cmd.valid       = r_valid;
    assign o_cmd.motor_id    = r_result.motor_id;
    assign o_cmd.motor_speed = r_result.motor_speed;

endmodule
